// ----- rtl/rtch_pkg.sv -----
// Types, widths and codes for the ray/triangle closest hit unit.
package rtch_pkg;

	localparam int COORD_W  = 16;   // Q8.8 positions and ray
	localparam int NRM_W    = 16;   // Q1.14 normals
	localparam int DIST_W   = 32;   // Q16.16 distances
	localparam int FRAC_W   = 16;   // fraction bits of distance and weights
	localparam int DIFF_W   = COORD_W + 1;       // edge / offset vectors
	localparam int NVEC_W   = 2 * DIFF_W + 1;    // u x v
	localparam int CVEC_W   = DIFF_W + COORD_W + 1; // v x d, a x d
	localparam int MA_W     = NVEC_W;            // wide multiplier operand
	localparam int MB_W     = DIFF_W;            // narrow multiplier operand
	localparam int ACC_W    = MA_W + MB_W;       // products and dot sums
	localparam int WGT_W    = FRAC_W + 1;        // weights, 0 .. 2^16
	localparam int AX_W     = NRM_W + WGT_W + 1; // normal interpolation sums
	localparam int STEP_W   = 6;
	localparam int CFG_IDX_W = 3;
	localparam int DIV_CNT_W = 5;

	localparam logic [STEP_W-1:0] STEP_A_LAST  = STEP_W'(30);
	localparam logic [STEP_W-1:0] STEP_B_FIRST = STEP_W'(32);
	localparam logic [STEP_W-1:0] STEP_B_LAST  = STEP_W'(41);
	localparam logic [DIV_CNT_W-1:0] DIST_ITERS_M1 = DIV_CNT_W'(DIST_W - 1);
	localparam logic [DIV_CNT_W-1:0] WGT_ITERS_M1  = DIV_CNT_W'(WGT_W - 1);
	localparam logic [WGT_W-1:0] WGT_ONE = WGT_W'(1) << FRAC_W;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ORIGIN_X = 3'd0,
		REG_ORIGIN_Y = 3'd1,
		REG_ORIGIN_Z = 3'd2,
		REG_DIR_X    = 3'd3,
		REG_DIR_Y    = 3'd4,
		REG_DIR_Z    = 3'd5,
		REG_MAX_DIST = 3'd6
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_LOAD, ST_MUL_A, ST_SIGN, ST_CHECK, ST_DIV_R, ST_DCHK,
		ST_DIV_S, ST_DIV_T, ST_WGT, ST_MUL_B, ST_FIN, ST_EMIT
	} state_t;

	typedef enum logic [3:0] {
		DST_NONE, DST_N0, DST_N1, DST_N2, DST_C0, DST_C1, DST_C2,
		DST_DEN, DST_RN, DST_SN, DST_TN, DST_AX0, DST_AX1, DST_AX2
	} dst_t;

	typedef struct packed {
		logic vld;
		logic first;
		logic neg;
		dst_t dst;
	} mul_op_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] pos_x;
		logic signed [COORD_W-1:0] pos_y;
		logic signed [COORD_W-1:0] pos_z;
		logic signed [NRM_W-1:0]   nrm_x;
		logic signed [NRM_W-1:0]   nrm_y;
		logic signed [NRM_W-1:0]   nrm_z;
		logic                      last_of_list;
	} vtx_t;

	typedef struct packed {
		logic                      hit_found;
		logic [DIST_W-1:0]         hit_distance;
		logic signed [NRM_W-1:0]   hit_nrm_x;
		logic signed [NRM_W-1:0]   hit_nrm_y;
		logic signed [NRM_W-1:0]   hit_nrm_z;
	} hit_t;

	// round half up by 2^16, then clamp to the normal range
	function automatic logic signed [NRM_W-1:0] rnd_sat(input logic signed [AX_W-1:0] x);
		logic signed [AX_W-1:0]        y;
		logic signed [AX_W-FRAC_W-1:0] r;
		y = x + AX_W'(1 << (FRAC_W - 1));
		r = y[AX_W-1:FRAC_W];
		if (r > (AX_W-FRAC_W)'(32767))
			return NRM_W'(32767);
		else if (r < -(AX_W-FRAC_W)'(32768))
			return NRM_W'(-32768);
		else
			return r[NRM_W-1:0];
	endfunction

endpackage

// ----- rtl/ray_triangle_closest_hit_unit.sv -----
// Closest hit of one ray against a stream of triangles, one shared multiplier.
//
// Usage: write the ray origin, direction and distance limit on the cfg channel
// (index 0..6, cfg_ready is always high) while the unit is idle. Then stream
// vertices on the in channel; every third vertex closes a triangle, which is
// tested against the ray. A vertex with last_of_list set makes the unit post
// one transaction on the out channel: hit flag, closest distance (or the
// limit) and the interpolated normal, after which the list state is cleared.
// Stalls: the first two vertices of a triangle are taken without a stall
// while no result is being posted. The third keeps in_stall high while the
// triangle is worked on: 30 products through the single multiplier, three
// restoring dividers of 32, 17 and 17 steps on the shared subtractor, then 9
// products for the normal; a rejected triangle stops before the divides, and
// one whose distance loses after the first; a list-ending vertex posts the result.
// in_stall is high while a triangle is being worked on and while a result is
// waiting to be loaded into the output register.
// The output register holds its transaction while out_stall is high; the unit
// keeps taking vertices meanwhile and only waits if a second result is due.
// Reset clears the list (no hit, limit all ones) and all ray registers.
module ray_triangle_closest_hit_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [rtch_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rtch_pkg::DIST_W-1:0]     cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  rtch_pkg::vtx_t                  in_data,
	output logic                            out_valid,
	input  logic                            out_stall,
	output rtch_pkg::hit_t                  out_data
);
	import rtch_pkg::*;

	// ray configuration
	logic signed [COORD_W-1:0] org_q [3];
	logic signed [COORD_W-1:0] dir_q [3];
	logic [DIST_W-1:0]         max_dist_q;

	// list state
	state_t                    state_q, state_d;
	logic [1:0]                slot_q;
	logic                      last_q;
	logic signed [COORD_W-1:0] hpos_q [2][3];
	logic signed [NRM_W-1:0]   hnrm_q [2][3];
	logic signed [COORD_W-1:0] v2pos_q [3];
	logic signed [NRM_W-1:0]   v2nrm_q [3];
	logic                      best_hit_q;
	logic [DIST_W-1:0]         best_dist_q;
	logic signed [NRM_W-1:0]   best_nrm_q [3];

	// triangle datapath
	logic signed [DIFF_W-1:0]  u_q [3];
	logic signed [DIFF_W-1:0]  v_q [3];
	logic signed [DIFF_W-1:0]  a_q [3];
	logic signed [NVEC_W-1:0]  n_q [3];
	logic signed [CVEC_W-1:0]  c_q [3];
	logic signed [ACC_W-1:0]   den_q, rn_q, sn_q, tn_q, acc_q;
	logic signed [AX_W-1:0]    ax_q [3];
	logic [STEP_W-1:0]         step_q;
	logic [DIST_W-1:0]         dist_q;
	logic [WGT_W-1:0]          sq_q, tq_q, w0_q;

	// shared multiplier
	logic signed [MA_W-1:0]    ma;
	logic signed [MB_W-1:0]    mb;
	mul_op_t                   op;
	logic signed [ACC_W-1:0]   prod_s1;
	mul_op_t                   op_s1;
	logic signed [ACC_W-1:0]   term, acc_new;

	// shared restoring divider
	logic [ACC_W-1:0]          dv_rem_q;
	logic [DIST_W-1:0]         dv_bits_q, dv_quo_q;
	logic [DIV_CNT_W-1:0]      dv_cnt_q;
	logic [ACC_W-1:0]          dv_r2, dv_rem_n;
	logic                      dv_ge;
	logic [DIST_W-1:0]         dv_quo_n;

	hit_t                      out_q;
	logic                      out_valid_q;

	logic                      in_acc, cfg_acc, emit_go;
	logic                      tri_reject, dist_sat, dist_reject;
	logic signed [ACC_W:0]     st_sum;
	logic [DIST_W-1:0]         cfg_limit, cur_limit;
	state_t                    done_state;

	assign cfg_ready = 1'b1;
	assign cfg_acc   = cfg_valid && cfg_ready;
	assign in_acc    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign emit_go   = !out_valid_q || !out_stall;

	assign cfg_limit = (cfg_data == '0) ? '1 : cfg_data;
	assign cur_limit = (max_dist_q == '0) ? '1 : max_dist_q;

	// triangle tests
	assign st_sum      = {sn_q[ACC_W-1], sn_q} + {tn_q[ACC_W-1], tn_q};
	assign tri_reject  = (den_q == '0) || sn_q[ACC_W-1] || tn_q[ACC_W-1] ||
	                     (st_sum > {den_q[ACC_W-1], den_q}) ||
	                     rn_q[ACC_W-1] || (rn_q == '0);
	// a quotient of 2^32 or more is rejected here: it can never win
	assign dist_sat    = (rn_q >>> FRAC_W) >= den_q;
	assign dist_reject = (dist_q == '0) || (dist_q >= best_dist_q);
	assign done_state  = last_q ? ST_EMIT : ST_IDLE;

	// divider step
	assign dv_r2    = {dv_rem_q[ACC_W-2:0], dv_bits_q[DIST_W-1]};
	assign dv_ge    = dv_r2 >= den_q;
	assign dv_rem_n = dv_ge ? dv_r2 - den_q : dv_r2;
	assign dv_quo_n = {dv_quo_q[DIST_W-2:0], dv_ge};

	// multiplier accumulate stage
	assign term    = op_s1.neg ? -prod_s1 : prod_s1;
	assign acc_new = op_s1.first ? term : acc_q + term;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (slot_q == 2'd2)
						state_d = ST_LOAD;
					else if (in_data.last_of_list)
						state_d = ST_EMIT;
				end
			end
			ST_LOAD:  state_d = ST_MUL_A;
			ST_MUL_A: if (step_q == STEP_A_LAST) state_d = ST_SIGN;
			ST_SIGN:  state_d = ST_CHECK;
			ST_CHECK: state_d = (tri_reject || dist_sat) ? done_state : ST_DIV_R;
			ST_DIV_R: if (dv_cnt_q == '0) state_d = ST_DCHK;
			ST_DCHK:  state_d = dist_reject ? done_state : ST_DIV_S;
			ST_DIV_S: if (dv_cnt_q == '0) state_d = ST_DIV_T;
			ST_DIV_T: if (dv_cnt_q == '0) state_d = ST_WGT;
			ST_WGT:   state_d = ST_MUL_B;
			ST_MUL_B: if (step_q == STEP_B_LAST) state_d = ST_FIN;
			ST_FIN:   state_d = done_state;
			ST_EMIT:  if (emit_go) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer: stall and multiplier program
	always_comb begin
		in_stall = (state_q != ST_IDLE);
		ma = '0;
		mb = '0;
		op = '{vld: 1'b1, first: 1'b0, neg: 1'b0, dst: DST_NONE};
		case (step_q)
			// n = u x v
			6'd0:  begin ma = MA_W'(u_q[1]); mb = v_q[2]; op.first = 1'b1; end
			6'd1:  begin ma = MA_W'(u_q[2]); mb = v_q[1]; op.neg = 1'b1; op.dst = DST_N0; end
			6'd2:  begin ma = MA_W'(u_q[2]); mb = v_q[0]; op.first = 1'b1; end
			6'd3:  begin ma = MA_W'(u_q[0]); mb = v_q[2]; op.neg = 1'b1; op.dst = DST_N1; end
			6'd4:  begin ma = MA_W'(u_q[0]); mb = v_q[1]; op.first = 1'b1; end
			6'd5:  begin ma = MA_W'(u_q[1]); mb = v_q[0]; op.neg = 1'b1; op.dst = DST_N2; end
			// den = n . d
			6'd6:  begin ma = n_q[0]; mb = MB_W'(dir_q[0]); op.first = 1'b1; end
			6'd7:  begin ma = n_q[1]; mb = MB_W'(dir_q[1]); end
			6'd8:  begin ma = n_q[2]; mb = MB_W'(dir_q[2]); op.dst = DST_DEN; end
			// rn = -(n . a)
			6'd9:  begin ma = n_q[0]; mb = a_q[0]; op.first = 1'b1; op.neg = 1'b1; end
			6'd10: begin ma = n_q[1]; mb = a_q[1]; op.neg = 1'b1; end
			6'd11: begin ma = n_q[2]; mb = a_q[2]; op.neg = 1'b1; op.dst = DST_RN; end
			// c = v x d
			6'd12: begin ma = MA_W'(v_q[1]); mb = MB_W'(dir_q[2]); op.first = 1'b1; end
			6'd13: begin ma = MA_W'(v_q[2]); mb = MB_W'(dir_q[1]); op.neg = 1'b1;
				op.dst = DST_C0; end
			6'd14: begin ma = MA_W'(v_q[2]); mb = MB_W'(dir_q[0]); op.first = 1'b1; end
			6'd15: begin ma = MA_W'(v_q[0]); mb = MB_W'(dir_q[2]); op.neg = 1'b1;
				op.dst = DST_C1; end
			6'd16: begin ma = MA_W'(v_q[0]); mb = MB_W'(dir_q[1]); op.first = 1'b1; end
			6'd17: begin ma = MA_W'(v_q[1]); mb = MB_W'(dir_q[0]); op.neg = 1'b1;
				op.dst = DST_C2; end
			// sn = a . c
			6'd18: begin ma = MA_W'(c_q[0]); mb = a_q[0]; op.first = 1'b1; end
			6'd19: begin ma = MA_W'(c_q[1]); mb = a_q[1]; end
			6'd20: begin ma = MA_W'(c_q[2]); mb = a_q[2]; op.dst = DST_SN; end
			// c = a x d
			6'd21: begin ma = MA_W'(a_q[1]); mb = MB_W'(dir_q[2]); op.first = 1'b1; end
			6'd22: begin ma = MA_W'(a_q[2]); mb = MB_W'(dir_q[1]); op.neg = 1'b1;
				op.dst = DST_C0; end
			6'd23: begin ma = MA_W'(a_q[2]); mb = MB_W'(dir_q[0]); op.first = 1'b1; end
			6'd24: begin ma = MA_W'(a_q[0]); mb = MB_W'(dir_q[2]); op.neg = 1'b1;
				op.dst = DST_C1; end
			6'd25: begin ma = MA_W'(a_q[0]); mb = MB_W'(dir_q[1]); op.first = 1'b1; end
			6'd26: begin ma = MA_W'(a_q[1]); mb = MB_W'(dir_q[0]); op.neg = 1'b1;
				op.dst = DST_C2; end
			// tn = u . c
			6'd27: begin ma = MA_W'(c_q[0]); mb = u_q[0]; op.first = 1'b1; end
			6'd28: begin ma = MA_W'(c_q[1]); mb = u_q[1]; end
			6'd29: begin ma = MA_W'(c_q[2]); mb = u_q[2]; op.dst = DST_TN; end
			// normal = N0*w0 + N1*sq + N2*tq per axis
			6'd32: begin ma = MA_W'($signed({1'b0, w0_q})); mb = MB_W'(hnrm_q[0][0]);
				op.first = 1'b1; end
			6'd33: begin ma = MA_W'($signed({1'b0, sq_q})); mb = MB_W'(hnrm_q[1][0]); end
			6'd34: begin ma = MA_W'($signed({1'b0, tq_q})); mb = MB_W'(v2nrm_q[0]);
				op.dst = DST_AX0; end
			6'd35: begin ma = MA_W'($signed({1'b0, w0_q})); mb = MB_W'(hnrm_q[0][1]);
				op.first = 1'b1; end
			6'd36: begin ma = MA_W'($signed({1'b0, sq_q})); mb = MB_W'(hnrm_q[1][1]); end
			6'd37: begin ma = MA_W'($signed({1'b0, tq_q})); mb = MB_W'(v2nrm_q[1]);
				op.dst = DST_AX1; end
			6'd38: begin ma = MA_W'($signed({1'b0, w0_q})); mb = MB_W'(hnrm_q[0][2]);
				op.first = 1'b1; end
			6'd39: begin ma = MA_W'($signed({1'b0, sq_q})); mb = MB_W'(hnrm_q[1][2]); end
			6'd40: begin ma = MA_W'($signed({1'b0, tq_q})); mb = MB_W'(v2nrm_q[2]);
				op.dst = DST_AX2; end
			default: op.vld = 1'b0;
		endcase
		if (state_q != ST_MUL_A && state_q != ST_MUL_B)
			op.vld = 1'b0;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			slot_q      <= 2'd0;
			last_q      <= 1'b0;
			step_q      <= '0;
			op_s1       <= '{vld: 1'b0, first: 1'b0, neg: 1'b0, dst: DST_NONE};
			out_valid_q <= 1'b0;
			best_hit_q  <= 1'b0;
			best_dist_q <= '1;
			best_nrm_q  <= '{default: '0};
			org_q       <= '{default: '0};
			dir_q       <= '{default: '0};
			max_dist_q  <= '0;
		end else begin
			state_q <= state_d;
			op_s1   <= op;

			if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						last_q <= in_data.last_of_list;
						slot_q <= (slot_q == 2'd2) ? 2'd0 : slot_q + 2'd1;
					end
				end
				ST_LOAD:  step_q <= '0;
				ST_MUL_A, ST_MUL_B: step_q <= step_q + STEP_W'(1);
				ST_WGT:   step_q <= STEP_B_FIRST;
				ST_FIN: begin
					best_hit_q  <= 1'b1;
					best_dist_q <= dist_q;
					for (int i = 0; i < 3; i++)
						best_nrm_q[i] <= rnd_sat(ax_q[i]);
				end
				ST_EMIT: begin
					if (emit_go) begin
						// result goes out, list starts over
						out_valid_q <= 1'b1;
						slot_q      <= 2'd0;
						best_hit_q  <= 1'b0;
						best_dist_q <= cur_limit;
						best_nrm_q  <= '{default: '0};
					end
				end
				default: ;
			endcase

			if (cfg_acc) begin
				unique case (cfg_index)
					REG_ORIGIN_X: org_q[0] <= cfg_data[COORD_W-1:0];
					REG_ORIGIN_Y: org_q[1] <= cfg_data[COORD_W-1:0];
					REG_ORIGIN_Z: org_q[2] <= cfg_data[COORD_W-1:0];
					REG_DIR_X:    dir_q[0] <= cfg_data[COORD_W-1:0];
					REG_DIR_Y:    dir_q[1] <= cfg_data[COORD_W-1:0];
					REG_DIR_Z:    dir_q[2] <= cfg_data[COORD_W-1:0];
					REG_MAX_DIST: begin
						max_dist_q <= cfg_data;
						if (!best_hit_q)
							best_dist_q <= cfg_limit;
					end
					default: ;
				endcase
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		prod_s1 <= ma * mb;

		if (state_q == ST_EMIT && emit_go) begin
			out_q.hit_found    <= best_hit_q;
			out_q.hit_distance <= best_dist_q;
			out_q.hit_nrm_x    <= best_nrm_q[0];
			out_q.hit_nrm_y    <= best_nrm_q[1];
			out_q.hit_nrm_z    <= best_nrm_q[2];
		end

		if (in_acc) begin
			if (slot_q == 2'd2) begin
				v2pos_q <= '{in_data.pos_x, in_data.pos_y, in_data.pos_z};
				v2nrm_q <= '{in_data.nrm_x, in_data.nrm_y, in_data.nrm_z};
			end else begin
				hpos_q[slot_q[0]] <= '{in_data.pos_x, in_data.pos_y, in_data.pos_z};
				hnrm_q[slot_q[0]] <= '{in_data.nrm_x, in_data.nrm_y, in_data.nrm_z};
			end
		end

		if (state_q == ST_LOAD) begin
			for (int i = 0; i < 3; i++) begin
				u_q[i] <= DIFF_W'(hpos_q[1][i]) - DIFF_W'(hpos_q[0][i]);
				v_q[i] <= DIFF_W'(v2pos_q[i]) - DIFF_W'(hpos_q[0][i]);
				a_q[i] <= DIFF_W'(org_q[i]) - DIFF_W'(hpos_q[0][i]);
			end
		end

		if (op_s1.vld) begin
			acc_q <= acc_new;
			case (op_s1.dst)
				DST_N0:  n_q[0] <= acc_new[NVEC_W-1:0];
				DST_N1:  n_q[1] <= acc_new[NVEC_W-1:0];
				DST_N2:  n_q[2] <= acc_new[NVEC_W-1:0];
				DST_C0:  c_q[0] <= acc_new[CVEC_W-1:0];
				DST_C1:  c_q[1] <= acc_new[CVEC_W-1:0];
				DST_C2:  c_q[2] <= acc_new[CVEC_W-1:0];
				DST_DEN: den_q  <= acc_new;
				DST_RN:  rn_q   <= acc_new;
				DST_SN:  sn_q   <= acc_new;
				DST_TN:  tn_q   <= acc_new;
				DST_AX0: ax_q[0] <= acc_new[AX_W-1:0];
				DST_AX1: ax_q[1] <= acc_new[AX_W-1:0];
				DST_AX2: ax_q[2] <= acc_new[AX_W-1:0];
				default: ;
			endcase
		end

		case (state_q)
			ST_SIGN: begin
				// make the denominator positive
				if (den_q[ACC_W-1]) begin
					den_q <= -den_q;
					rn_q  <= -rn_q;
					sn_q  <= -sn_q;
					tn_q  <= -tn_q;
				end
			end
			ST_CHECK: begin
				dv_rem_q  <= ACC_W'(rn_q >>> FRAC_W);
				dv_bits_q <= {rn_q[FRAC_W-1:0], {(DIST_W-FRAC_W){1'b0}}};
				dv_quo_q  <= '0;
				dv_cnt_q  <= DIST_ITERS_M1;
			end
			ST_DIV_R: begin
				dv_rem_q  <= dv_rem_n;
				dv_bits_q <= dv_bits_q << 1;
				dv_quo_q  <= dv_quo_n;
				dv_cnt_q  <= dv_cnt_q - DIV_CNT_W'(1);
				if (dv_cnt_q == '0)
					dist_q <= dv_quo_n;
			end
			ST_DCHK: begin
				dv_rem_q  <= ACC_W'(sn_q >>> 1);
				dv_bits_q <= {sn_q[0], {(DIST_W-1){1'b0}}};
				dv_quo_q  <= '0;
				dv_cnt_q  <= WGT_ITERS_M1;
			end
			ST_DIV_S: begin
				if (dv_cnt_q == '0) begin
					sq_q      <= dv_quo_n[WGT_W-1:0];
					dv_rem_q  <= ACC_W'(tn_q >>> 1);
					dv_bits_q <= {tn_q[0], {(DIST_W-1){1'b0}}};
					dv_quo_q  <= '0;
					dv_cnt_q  <= WGT_ITERS_M1;
				end else begin
					dv_rem_q  <= dv_rem_n;
					dv_bits_q <= dv_bits_q << 1;
					dv_quo_q  <= dv_quo_n;
					dv_cnt_q  <= dv_cnt_q - DIV_CNT_W'(1);
				end
			end
			ST_DIV_T: begin
				dv_rem_q  <= dv_rem_n;
				dv_bits_q <= dv_bits_q << 1;
				dv_quo_q  <= dv_quo_n;
				dv_cnt_q  <= dv_cnt_q - DIV_CNT_W'(1);
				if (dv_cnt_q == '0)
					tq_q <= dv_quo_n[WGT_W-1:0];
			end
			ST_WGT: w0_q <= WGT_ONE - sq_q - tq_q;
			default: ;
		endcase
	end

endmodule

// ----- dv/ray_triangle_closest_hit_unit_tb.sv -----
// Self-checking testbench for the ray/triangle closest hit unit.
module ray_triangle_closest_hit_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import rtch_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int SETTLE_CYCLES = 300;   // well above the longest path of one triangle
	localparam int RANDOM_ITEMS = 1900;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [DIST_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	vtx_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	hit_t out_data;

	ray_triangle_closest_hit_unit uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	always #5 clk = ~clk;

	// ---------------------------------------------------------------
	// Hit predictor: ray registers, held vertices, best hit so far
	// ---------------------------------------------------------------
	longint ray_org[3];
	longint ray_dir[3];
	logic [DIST_W-1:0] dist_limit;
	int vtx_slot;
	longint held_pos[6];
	longint held_nrm[6];
	longint unsigned best_dist;
	bit best_valid;
	longint best_nrm[3];

	hit_t hits_due[$];      // expected result transactions, oldest first
	vtx_t vtx_pending[$];   // vertices waiting for the driver

	int mismatches = 0;
	int lists_done = 0;
	int hits_seen = 0;
	int vtx_accepted = 0;
	int cycles = 0;

	function automatic longint unsigned eff_limit();
		return (dist_limit == '0) ? 64'hFFFF_FFFF : longint'(dist_limit);
	endfunction

	// floor(num * 2^16 / den), clamped to lim
	function automatic longint unsigned frac_quot(longint unsigned num, longint unsigned den,
			longint unsigned lim);
		longint unsigned q, r;
		q = num / den;
		r = num % den;
		if (q > (lim >> FRAC_W))
			return lim;
		for (int i = 0; i < FRAC_W; i++) begin
			r = r << 1;
			q = q << 1;
			if (r >= den) begin
				r = r - den;
				q = q | 64'd1;
			end
		end
		return (q > lim) ? lim : q;
	endfunction

	function automatic longint dot(longint p0, longint p1, longint p2,
			longint q0, longint q1, longint q2);
		return p0 * q0 + p1 * q1 + p2 * q2;
	endfunction

	function automatic void list_clear();
		vtx_slot = 0;
		best_valid = 0;
		best_dist = eff_limit();
		best_nrm = '{0, 0, 0};
	endfunction

	function automatic void queue_vtx(vtx_t vx);
		vtx_pending.insert(vtx_pending.size(), vx);
	endfunction

	function automatic void tri_test(longint p[3], longint q[3]);
		longint u[3], v[3], a[3], n[3], c[3];
		longint den, rn, sn, tn, acc, r;
		longint unsigned hit_d, lim, sq, tq, w0;
		for (int i = 0; i < 3; i++) begin
			u[i] = held_pos[3 + i] - held_pos[i];
			v[i] = p[i] - held_pos[i];
			a[i] = ray_org[i] - held_pos[i];
		end
		n[0] = u[1] * v[2] - u[2] * v[1];
		n[1] = u[2] * v[0] - u[0] * v[2];
		n[2] = u[0] * v[1] - u[1] * v[0];
		den = dot(n[0], n[1], n[2], ray_dir[0], ray_dir[1], ray_dir[2]);
		if (den == 0)
			return;   // parallel ray or degenerate triangle
		rn = -dot(n[0], n[1], n[2], a[0], a[1], a[2]);
		c[0] = v[1] * ray_dir[2] - v[2] * ray_dir[1];
		c[1] = v[2] * ray_dir[0] - v[0] * ray_dir[2];
		c[2] = v[0] * ray_dir[1] - v[1] * ray_dir[0];
		sn = dot(a[0], a[1], a[2], c[0], c[1], c[2]);
		c[0] = a[1] * ray_dir[2] - a[2] * ray_dir[1];
		c[1] = a[2] * ray_dir[0] - a[0] * ray_dir[2];
		c[2] = a[0] * ray_dir[1] - a[1] * ray_dir[0];
		tn = dot(u[0], u[1], u[2], c[0], c[1], c[2]);
		if (den < 0) begin
			den = -den; rn = -rn; sn = -sn; tn = -tn;
		end
		if (sn < 0 || tn < 0 || sn + tn > den || rn <= 0)
			return;
		hit_d = frac_quot(rn, den, 64'hFFFF_FFFF);
		lim = best_valid ? best_dist : eff_limit();
		if (hit_d == 0 || hit_d >= lim)
			return;   // equal distance is not taken
		sq = frac_quot(sn, den, 64'd1 << FRAC_W);
		tq = frac_quot(tn, den, 64'd1 << FRAC_W);
		w0 = (64'd1 << FRAC_W) - sq - tq;
		for (int i = 0; i < 3; i++) begin
			acc = held_nrm[i] * longint'(w0) + held_nrm[3 + i] * longint'(sq)
				+ q[i] * longint'(tq);
			r = (acc + 32768) >>> FRAC_W;
			if (r > 32767) r = 32767;
			if (r < -32768) r = -32768;
			best_nrm[i] = r;
		end
		best_dist = hit_d;
		best_valid = 1;
	endfunction

	function automatic void vtx_predict(vtx_t vx);
		longint p[3], q[3];
		hit_t h;
		p = '{longint'(vx.pos_x), longint'(vx.pos_y), longint'(vx.pos_z)};
		q = '{longint'(vx.nrm_x), longint'(vx.nrm_y), longint'(vx.nrm_z)};
		if (vtx_slot >= 2) begin
			tri_test(p, q);
			vtx_slot = 0;
		end else begin
			for (int i = 0; i < 3; i++) begin
				held_pos[vtx_slot * 3 + i] = p[i];
				held_nrm[vtx_slot * 3 + i] = q[i];
			end
			vtx_slot++;
		end
		if (vx.last_of_list) begin
			h.hit_found = best_valid;
			h.hit_distance = best_valid ? best_dist[31:0] : DIST_W'(eff_limit());
			h.hit_nrm_x = best_nrm[0][15:0];
			h.hit_nrm_y = best_nrm[1][15:0];
			h.hit_nrm_z = best_nrm[2][15:0];
			hits_due.insert(hits_due.size(), h);
			list_clear();
		end
	endfunction

	function automatic void cfg_predict(logic [CFG_IDX_W-1:0] idx, logic [DIST_W-1:0] val);
		case (idx)
			REG_ORIGIN_X: ray_org[0] = longint'($signed(val[15:0]));
			REG_ORIGIN_Y: ray_org[1] = longint'($signed(val[15:0]));
			REG_ORIGIN_Z: ray_org[2] = longint'($signed(val[15:0]));
			REG_DIR_X:    ray_dir[0] = longint'($signed(val[15:0]));
			REG_DIR_Y:    ray_dir[1] = longint'($signed(val[15:0]));
			REG_DIR_Z:    ray_dir[2] = longint'($signed(val[15:0]));
			REG_MAX_DIST: begin
				dist_limit = val;
				if (!best_valid)
					best_dist = eff_limit();
			end
			default: ;   // out-of-range index is ignored
		endcase
	endfunction

	// ---------------------------------------------------------------
	// Driver, receiver and monitor
	// ---------------------------------------------------------------
	int send_idle_pct = 15;
	int recv_idle_pct = 50;
	int hold_cycles = 0;   // long receiver hold-off, counted down here
	bit in_taken = 0;

	always @(negedge clk) begin
		if (!in_valid || in_taken) begin
			in_taken = 0;
			if (vtx_pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				in_data <= vtx_pending.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		hit_t want;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				hits_due.size());
			$display("tb: failure");
			$finish;
		end else begin
			if (arst_n && in_valid && !in_stall) begin
				vtx_predict(in_data);
				vtx_accepted++;
				in_taken = 1;
			end
			if (arst_n && out_valid && !out_stall) begin
				lists_done++;
				if (out_data.hit_found) hits_seen++;
				if (hits_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result transaction %p", out_data);
				end else begin
					want = hits_due.pop_front();
					if (out_data.hit_found !== want.hit_found
						|| out_data.hit_distance !== want.hit_distance
						|| out_data.hit_nrm_x !== want.hit_nrm_x
						|| out_data.hit_nrm_y !== want.hit_nrm_y
						|| out_data.hit_nrm_z !== want.hit_nrm_z) begin
						mismatches++;
						if (mismatches <= 10)
							$display("result mismatch: expected %p, got %p", want, out_data);
					end
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------
	function automatic logic signed [15:0] clamp16(longint x);
		if (x > 32767) return 16'sd32767;
		if (x < -32768) return -16'sd32768;
		return x[15:0];
	endfunction

	function automatic vtx_t mk_vtx(longint x, longint y, longint z,
			longint nx, longint ny, longint nz, bit last);
		vtx_t vx;
		vx.pos_x = clamp16(x); vx.pos_y = clamp16(y); vx.pos_z = clamp16(z);
		vx.nrm_x = clamp16(nx); vx.nrm_y = clamp16(ny); vx.nrm_z = clamp16(nz);
		vx.last_of_list = last;
		return vx;
	endfunction

	function automatic longint srand(int span);
		return longint'($urandom_range(2 * span)) - span;
	endfunction

	function automatic longint rnd_nrm();
		// mostly unit-ish normals, sometimes full range to push saturation
		if ($urandom_range(3) == 0)
			return longint'($signed(16'($urandom)));
		return srand(16384);
	endfunction

	// vertex near a point on the current ray, so many triangles are hit
	function automatic vtx_t ray_vtx(longint k, int spread, bit last);
		return mk_vtx(ray_org[0] + ((ray_dir[0] * k) >>> 8) + srand(spread),
			ray_org[1] + ((ray_dir[1] * k) >>> 8) + srand(spread),
			ray_org[2] + ((ray_dir[2] * k) >>> 8) + srand(spread),
			rnd_nrm(), rnd_nrm(), rnd_nrm(), last);
	endfunction

	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [DIST_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_predict(idx, val);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_ray(longint ox, longint oy, longint oz,
			longint dx, longint dy, longint dz, logic [DIST_W-1:0] lim);
		cfg_write(REG_ORIGIN_X, DIST_W'(ox));
		cfg_write(REG_ORIGIN_Y, DIST_W'(oy));
		cfg_write(REG_ORIGIN_Z, DIST_W'(oz));
		cfg_write(REG_DIR_X, DIST_W'(dx));
		cfg_write(REG_DIR_Y, DIST_W'(dy));
		cfg_write(REG_DIR_Z, DIST_W'(dz));
		cfg_write(REG_MAX_DIST, lim);
	endtask

	// block is idle: nothing queued, nothing due, and a triangle that ends
	// no list has had time to finish
	task automatic drain();
		while (vtx_pending.size() > 0 || in_valid || hits_due.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// one well-formed list, mostly on the current ray; sometimes cut short
	task automatic queue_list(int ntri, int spread, output int count);
		int nv, cut;
		longint k;
		nv = ntri * 3;
		cut = ($urandom_range(9) == 0) ? $urandom_range(2, 1) : 0;
		nv = nv - cut;
		for (int i = 0; i < nv; i++) begin
			if (i % 3 == 0) k = longint'($urandom_range(1800, 64));
			if ($urandom_range(15) == 0)
				queue_vtx(mk_vtx(srand(32768), srand(32768), srand(32768),
					rnd_nrm(), rnd_nrm(), rnd_nrm(), i == nv - 1));
			else
				queue_vtx(ray_vtx(k, spread, i == nv - 1));
		end
		count = nv;
	endtask

	// ---------------------------------------------------------------
	// Test sequence
	// ---------------------------------------------------------------
	initial begin
		int queued, n;
		ray_org = '{0, 0, 0};
		ray_dir = '{0, 0, 0};
		dist_limit = '0;
		held_pos = '{default: 0};
		held_nrm = '{default: 0};
		list_clear();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: ray along +z from the origin
		set_ray(0, 0, 0, 0, 0, 256, 0);
		// plain hit at z = 2.0, unlimited distance
		queue_vtx(mk_vtx(-512, -512, 512, 16384, 0, 0, 0));
		queue_vtx(mk_vtx(512, -512, 512, 0, 16384, 0, 0));
		queue_vtx(mk_vtx(-512, 512, 512, 0, 0, 16384, 1));
		// same triangle twice: equal distance is not taken, nearer one wins
		queue_vtx(mk_vtx(-512, -512, 768, 32767, 32767, 32767, 0));
		queue_vtx(mk_vtx(512, -512, 768, 32767, 32767, 32767, 0));
		queue_vtx(mk_vtx(-512, 512, 768, 32767, 32767, 32767, 0));
		queue_vtx(mk_vtx(-512, -512, 768, -32768, 0, 0, 0));
		queue_vtx(mk_vtx(512, -512, 768, -32768, 0, 0, 0));
		queue_vtx(mk_vtx(-512, 512, 768, -32768, 0, 0, 0));
		queue_vtx(mk_vtx(-512, -512, 256, 0, -32768, 0, 0));
		queue_vtx(mk_vtx(512, -512, 256, 0, -32768, 0, 0));
		queue_vtx(mk_vtx(-512, 512, 256, 0, -32768, 0, 1));
		// degenerate triangle, then a triangle parallel to the ray
		queue_vtx(mk_vtx(100, 100, 100, 0, 0, 0, 0));
		queue_vtx(mk_vtx(100, 100, 100, 0, 0, 0, 0));
		queue_vtx(mk_vtx(100, 100, 100, 0, 0, 0, 0));
		queue_vtx(mk_vtx(0, -512, -512, 0, 0, 0, 0));
		queue_vtx(mk_vtx(0, 512, -512, 0, 0, 0, 0));
		queue_vtx(mk_vtx(0, 0, 512, 0, 0, 0, 1));
		// list ending after one vertex, then after two
		queue_vtx(mk_vtx(32767, 32767, 32767, 32767, 32767, 32767, 1));
		queue_vtx(mk_vtx(-32768, -32768, -32768, -32768, -32768, -32768, 0));
		queue_vtx(mk_vtx(32767, -32768, 32767, -32768, 32767, -32768, 1));
		// extreme positions forming a huge triangle
		queue_vtx(mk_vtx(-32768, -32768, 32767, 16384, 16384, 16384, 0));
		queue_vtx(mk_vtx(32767, -32768, 32767, 16384, 16384, 16384, 0));
		queue_vtx(mk_vtx(-32768, 32767, 32767, 16384, 16384, 16384, 1));
		drain();

		// tight limit rejects the hit; limit rewritten mid-list reloads it
		cfg_write(REG_MAX_DIST, 32'h0001_0000);
		queue_vtx(mk_vtx(-512, -512, 512, 0, 0, 16384, 0));
		queue_vtx(mk_vtx(512, -512, 512, 0, 0, 16384, 0));
		queue_vtx(mk_vtx(-512, 512, 512, 0, 0, 16384, 0));
		queue_vtx(mk_vtx(-512, -512, 512, 0, 0, 16384, 0));
		drain();
		cfg_write(REG_MAX_DIST, 32'hFFFF_FFFF);
		cfg_write(3'd7, 32'hDEAD_BEEF);   // no such register
		queue_vtx(mk_vtx(512, -512, 512, 0, 0, 16384, 0));
		queue_vtx(mk_vtx(-512, 512, 512, 0, 0, 16384, 1));
		drain();

		// zero direction: nothing is ever hit
		set_ray(-32768, 32767, 0, 0, 0, 0, 0);
		queue_vtx(mk_vtx(-512, -512, 512, 0, 0, 16384, 0));
		queue_vtx(mk_vtx(512, -512, 512, 0, 0, 16384, 0));
		queue_vtx(mk_vtx(-512, 512, 512, 0, 0, 16384, 1));
		drain();

		// random part: well-formed lists on random rays, some noise
		queued = 0;
		while (queued < RANDOM_ITEMS) begin
			if (queued > RANDOM_ITEMS / 3 && send_idle_pct == 15) begin
				send_idle_pct = 50;
				recv_idle_pct = 15;
			end else if (queued > 2 * RANDOM_ITEMS / 3 && send_idle_pct == 50) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			drain();
			case ($urandom_range(7))
				0: set_ray(srand(32768), srand(32768), srand(32768),
					srand(32768), srand(32768), srand(32768), $urandom);
				1: set_ray(srand(512), srand(512), srand(512),
					srand(512), srand(512), srand(512), $urandom_range(1 << 20, 1));
				default: set_ray(srand(1024), srand(1024), srand(1024),
					srand(512), srand(512), srand(512), 0);
			endcase
			if (queued > RANDOM_ITEMS / 2 && queued < RANDOM_ITEMS / 2 + 160) begin
				// receiver holds off while short lists pile up behind it
				hold_cycles = 1500;
				for (int i = 0; i < 30; i++) begin
					queue_list(1, 300, n);
					queued += n;
				end
			end else begin
				for (int i = 0; i < 8; i++) begin
					queue_list($urandom_range(4, 1), $urandom_range(3) == 0 ? 4000 : 400, n);
					queued += n;
				end
				for (int i = 0; i < 6; i++) begin
					queue_vtx(mk_vtx(srand(32768), srand(32768), srand(32768),
						srand(32768), srand(32768), srand(32768), $urandom_range(5) == 0));
					queued++;
				end
				queue_vtx(ray_vtx(256, 400, 1));   // close any open list
				queued++;
			end
		end

		drain();
		$display("covered %0d vertices and %0d result transactions, %0d with a hit",
			vtx_accepted, lists_done, hits_seen);
		$display("rays: directed axis cases, zero direction, limits and random rays");
		if (mismatches == 0)
			$display("tb: success");
		else begin
			$display("%0d mismatches", mismatches);
			$display("tb: failure");
		end
		$finish;
	end

endmodule
